// ===== rtl/ucp_pkg.sv =====
`timescale 1ns / 1ps
package ucp_pkg;
  localparam int ADDR_W     = 64;
  localparam int UNIT_W     = 32;
  localparam int ALIGN_W    = 17;
  localparam int VA_W       = 6;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 64;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = 1;
  localparam int CNT_W      = 2;
  localparam int NSTG       = ADDR_W;
  localparam logic [VA_W-1:0] VA_MIN = 6'd48;
  localparam logic [VA_W-1:0] VA_MAX = 6'd57;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_BAD_SPAN = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ALIGN = 3'd0,
    REG_MIN   = 3'd1,
    REG_MAX   = 3'd2,
    REG_UNIT  = 3'd3,
    REG_VA    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ALIGN_W-1:0] align;
    logic [ADDR_W-1:0]  min_len;
    logic [ADDR_W-1:0]  max_len;
    logic [UNIT_W-1:0]  unit;
    logic [VA_W-1:0]    va;
  } cfg_t;

  typedef struct packed {
    logic              early_hit;
    status_t           early_code;
    status_t           late_code;
    logic              unit_zero;
    logic [ADDR_W-1:0] len;
  } item_t;

  function automatic logic non_canonical(input logic [ADDR_W-1:0] a,
                                         input logic [VA_W-1:0] bits);
    logic bad;
    bad = 1'b0;
    for (int i = 47; i < ADDR_W; i++) begin
      if (7'(i) >= ({1'b0, bits} - 7'd1) && a[i] != a[ADDR_W-1]) bad = 1'b1;
    end
    return bad;
  endfunction
endpackage

// ===== rtl/ucp_front.sv =====
`timescale 1ns / 1ps
module ucp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ucp_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [ucp_pkg::ADDR_W-1:0] in_start,
  input  logic [ucp_pkg::ADDR_W-1:0] in_other,
  output logic                      item_valid,
  input  logic                      item_ready,
  output ucp_pkg::item_t            item
);
  logic                       v_r, v_nxt;
  ucp_pkg::item_t             item_r, item_nxt;
  logic [ucp_pkg::ADDR_W-1:0] len, end_a, mask;
  logic                       carry, neg, bad_align, bad_lim;
  logic [ucp_pkg::VA_W-1:0]   vab;

  assign in_ready   = !v_r || item_ready;
  assign item_valid = v_r;
  assign item       = item_r;

  always_comb begin
    len = in_mode ? in_other - in_start : in_other;
    neg = in_mode && (in_start > in_other);
    if (in_mode) {carry, end_a} = {1'b0, in_other};
    else {carry, end_a} = {1'b0, in_start} + {1'b0, in_other};
    if (cfg.align == '0) mask = '1;
    else mask = {{(ucp_pkg::ADDR_W-ucp_pkg::ALIGN_W){1'b0}},
                 cfg.align - ucp_pkg::ALIGN_W'(1)};
    bad_align = |(in_start & mask);
    bad_lim   = (len < cfg.min_len) || (len > cfg.max_len);
    if (cfg.va < ucp_pkg::VA_MIN) vab = ucp_pkg::VA_MIN;
    else if (cfg.va > ucp_pkg::VA_MAX) vab = ucp_pkg::VA_MAX;
    else vab = cfg.va;
    item_nxt.len       = len;
    item_nxt.unit_zero = (cfg.unit == '0);
    item_nxt.early_hit = 1'b1;
    priority if (neg) item_nxt.early_code = ucp_pkg::ST_BAD_SPAN;
    else if (bad_align) item_nxt.early_code = ucp_pkg::ST_BAD_ADDR;
    else if (bad_lim) item_nxt.early_code = ucp_pkg::ST_BAD_SPAN;
    else begin
      item_nxt.early_code = ucp_pkg::ST_OK;
      item_nxt.early_hit  = 1'b0;
    end
    priority if (carry) item_nxt.late_code = ucp_pkg::ST_BAD_SPAN;
    else if (ucp_pkg::non_canonical(in_start, vab) || ucp_pkg::non_canonical(end_a, vab)
             || in_start[ucp_pkg::ADDR_W-1] || end_a[ucp_pkg::ADDR_W-1])
      item_nxt.late_code = ucp_pkg::ST_BAD_ADDR;
    else item_nxt.late_code = ucp_pkg::ST_OK;
    v_nxt = in_ready ? in_valid : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= v_nxt;
    if (in_ready) item_r <= item_nxt;
  end
endmodule

// ===== rtl/ucp_queue.sv =====
`timescale 1ns / 1ps
module ucp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ucp_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ucp_pkg::item_t pop_item
);
  ucp_pkg::item_t            mem_r [ucp_pkg::FIFO_DEPTH];
  logic [ucp_pkg::PTR_W-1:0] wr_r, rd_r;
  logic [ucp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      push, pop;

  assign push_ready = cnt_r != ucp_pkg::CNT_W'(ucp_pkg::FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
    end
    if (push) mem_r[wr_r] <= push_item;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ucp_pkg::CNT_W'(ucp_pkg::FIFO_DEPTH))
    else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wr_r == rd_r)
    else $error("queue pointers out of step");
endmodule

// ===== rtl/ucp_back.sv =====
`timescale 1ns / 1ps
module ucp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ucp_pkg::UNIT_W-1:0] unit,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  ucp_pkg::item_t             item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ucp_pkg::status_t           out_status
);
  logic                       v_r   [ucp_pkg::NSTG];
  logic [ucp_pkg::UNIT_W-1:0] rem_r [ucp_pkg::NSTG];
  ucp_pkg::item_t             it_r  [ucp_pkg::NSTG];
  logic                       v_nxt   [ucp_pkg::NSTG];
  logic [ucp_pkg::UNIT_W-1:0] rem_nxt [ucp_pkg::NSTG];
  ucp_pkg::item_t             it_nxt  [ucp_pkg::NSTG];
  logic                       en;
  ucp_pkg::item_t             last;

  assign en         = !v_r[ucp_pkg::NSTG-1] || out_ready;
  assign item_ready = en;
  assign out_valid  = v_r[ucp_pkg::NSTG-1];
  assign last       = it_r[ucp_pkg::NSTG-1];

  // one quotient bit per stage, msb of the length first
  for (genvar s = 0; s < ucp_pkg::NSTG; s++) begin : g_stg
    logic                       sv;
    logic [ucp_pkg::UNIT_W-1:0] srem;
    ucp_pkg::item_t             sit;
    logic [ucp_pkg::UNIT_W:0]   t;
    if (s == 0) begin : g_head
      assign sv   = item_valid;
      assign srem = '0;
      assign sit  = item;
    end else begin : g_tail
      assign sv   = v_r[s-1];
      assign srem = rem_r[s-1];
      assign sit  = it_r[s-1];
    end
    always_comb begin
      t = {srem, sit.len[ucp_pkg::ADDR_W-1]};
      if (t >= {1'b0, unit}) rem_nxt[s] = ucp_pkg::UNIT_W'(t - {1'b0, unit});
      else rem_nxt[s] = t[ucp_pkg::UNIT_W-1:0];
      it_nxt[s]     = sit;
      it_nxt[s].len = {sit.len[ucp_pkg::ADDR_W-2:0], 1'b0};
      v_nxt[s]      = sv;
    end
  end

  always_comb begin
    if (last.early_hit) out_status = last.early_code;
    else if (!last.unit_zero && rem_r[ucp_pkg::NSTG-1] != '0)
      out_status = ucp_pkg::ST_BAD_SPAN;
    else out_status = last.late_code;
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ucp_pkg::NSTG; s++) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_nxt[s];
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        it_r[s]  <= it_nxt[s];
      end
    end
  end

  a_rem_lt_unit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ucp_pkg::NSTG-1] && unit != '0 |-> rem_r[ucp_pkg::NSTG-1] < unit)
    else $error("remainder not reduced");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(rem_r[ucp_pkg::NSTG-1]))
    else $error("pipeline moved while stalled");
  a_len_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last.len == '0)
    else $error("length bits left at pipeline end");
endmodule

// ===== rtl/user_pointer_range_checker.sv =====
`timescale 1ns / 1ps
// path from input word to result word: front register, queue, 64 remainder stages
// throughput: one word per cycle (one-bit-per-stage remainder pipeline) unless out_tready stalls
// the 2-entry queue lets the front take words while the result side stalls, until it fills
// reset: synchronous active-low rst_n empties all stages and restores register defaults
module user_pointer_range_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ucp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ucp_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [127:0]                in_tdata,  // start_address, size_or_end
  input  logic                        in_tuser,  // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata  // check_status, zero pad
);
  ucp_pkg::cfg_t    cfg_r;
  ucp_pkg::item_t   f_item, q_item;
  logic             f_valid, f_ready, q_valid, q_ready;
  ucp_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.align   <= ucp_pkg::ALIGN_W'(1);
      cfg_r.min_len <= '0;
      cfg_r.max_len <= '1;
      cfg_r.unit    <= ucp_pkg::UNIT_W'(1);
      cfg_r.va      <= ucp_pkg::VA_MIN;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ucp_pkg::REG_ALIGN: cfg_r.align   <= cfg_wdata[ucp_pkg::ALIGN_W-1:0];
        ucp_pkg::REG_MIN:   cfg_r.min_len <= cfg_wdata;
        ucp_pkg::REG_MAX:   cfg_r.max_len <= cfg_wdata;
        ucp_pkg::REG_UNIT:  cfg_r.unit    <= cfg_wdata[ucp_pkg::UNIT_W-1:0];
        ucp_pkg::REG_VA:    cfg_r.va      <= cfg_wdata[ucp_pkg::VA_W-1:0];
        default: ;
      endcase
    end
  end

  ucp_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_mode(in_tuser),
    .in_start(in_tdata[63:0]), .in_other(in_tdata[127:64]),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  ucp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
  );

  ucp_back u_back (
    .clk(clk), .rst_n(rst_n), .unit(cfg_r.unit),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_status(status)
  );

  assign out_tdata = {6'd0, status};
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic        mode;
    logic [63:0] start_addr;
    logic [63:0] other;
  } req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [ucp_pkg::IDX_W-1:0]  cfg_index;
  logic [ucp_pkg::DATA_W-1:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [127:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  user_pointer_range_checker dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [16:0] m_align;
  logic [63:0] m_min;
  logic [63:0] m_max;
  logic [31:0] m_unit;
  logic [5:0]  m_va;

  req_t              pending_q[$];
  ucp_pkg::status_t  status_q[$];
  int          errors;
  bit          src_busy;
  bit          quiet;

  function automatic bit is_canonical(logic [63:0] a, int bits);
    logic [63:0] top;
    logic [63:0] ones;
    top = a >> (bits - 1);
    ones = {64{1'b1}} >> (bits - 1);
    return top == 0 || top == ones;
  endfunction

  function automatic ucp_pkg::status_t span_status(logic [63:0] s, logic [63:0] len);
    logic [63:0] mask;
    logic [64:0] sum;
    logic [63:0] fin;
    int bits;
    mask = {47'd0, m_align} - 64'd1;
    if ((s & mask) != 0) return ucp_pkg::ST_BAD_ADDR;
    if (len < m_min || len > m_max) return ucp_pkg::ST_BAD_SPAN;
    if (m_unit != 0 && (len % {32'd0, m_unit}) != 0) return ucp_pkg::ST_BAD_SPAN;
    sum = {1'b0, s} + {1'b0, len};
    if (sum[64]) return ucp_pkg::ST_BAD_SPAN;
    fin = sum[63:0];
    bits = m_va;
    if (bits < 48) bits = 48;
    if (bits > 57) bits = 57;
    if (!is_canonical(s, bits) || !is_canonical(fin, bits)) return ucp_pkg::ST_BAD_ADDR;
    if (s[63] || fin[63]) return ucp_pkg::ST_BAD_ADDR;
    return ucp_pkg::ST_OK;
  endfunction

  function automatic ucp_pkg::status_t range_status(req_t r);
    if (r.mode) begin
      if (r.start_addr > r.other) return ucp_pkg::ST_BAD_SPAN;
      return span_status(r.start_addr, r.other - r.start_addr);
    end
    return span_status(r.start_addr, r.other);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 30)) begin
        req_t r;
        r = pending_q.pop_front();
        status_q.push_back(range_status(r));
        in_tvalid <= 1'b1;
        in_tdata <= {r.other, r.start_addr};
        in_tuser <= r.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= quiet || ($urandom_range(99) >= 30);
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %0h", out_tdata);
        end else begin
          ucp_pkg::status_t e;
          e = status_q.pop_front();
          if (out_tdata != {6'd0, e}) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %0d actual %0d", e, out_tdata);
          end
        end
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(5))
      0: return rnd64();
      1: return {16'h0000, 16'($urandom_range(65535)), $urandom} & ~64'hF;
      2: return {8'h00, 8'($urandom_range(255)), 16'h0, $urandom};
      3: return 64'h0000_7fff_ffff_0000 + {44'd0, 16'($urandom_range(65535)), 4'h0};
      4: return {16'hffff, 16'h8000 | 16'($urandom_range(65535)), $urandom};
      default: return {16'h0, 16'($urandom_range(65535)), $urandom};
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    logic [63:0] len;
    r.mode = 1'($urandom_range(1));
    r.start_addr = pick_addr();
    case ($urandom_range(4))
      0: len = rnd64();
      1: len = {32'd0, $urandom_range(4096)} & ~64'h7;
      2: len = {32'd0, $urandom};
      3: len = 64'd0;
      default: len = {32'd0, $urandom_range(256)};
    endcase
    if (r.mode) r.other = ($urandom_range(9) == 0) ? rnd64() : r.start_addr + len;
    else r.other = len;
    if ($urandom_range(19) == 0) r.start_addr = rnd64();
    return r;
  endfunction

  task automatic write_reg(ucp_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      ucp_pkg::REG_ALIGN: m_align = val[16:0];
      ucp_pkg::REG_MIN:   m_min = val;
      ucp_pkg::REG_MAX:   m_max = val;
      ucp_pkg::REG_UNIT:  m_unit = val[31:0];
      ucp_pkg::REG_VA:    m_va = val[5:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_q.size() > 0 || status_q.size() > 0 || in_tvalid) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $display("status: fail");
      $finish;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic push_dir(logic mode, logic [63:0] s, logic [63:0] o);
    req_t r;
    r.mode = mode;
    r.start_addr = s;
    r.other = o;
    pending_q.push_back(r);
  endtask

  initial begin
    int ph;
    errors = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    m_align = 17'd1;
    m_min = 64'd0;
    m_max = {64{1'b1}};
    m_unit = 32'd1;
    m_va = 6'd48;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    push_dir(1'b0, 64'd0, 64'd0);
    push_dir(1'b0, {64{1'b1}}, {64{1'b1}});
    push_dir(1'b0, 64'h1000, {64{1'b1}});
    push_dir(1'b1, 64'h2000, 64'h1000);
    push_dir(1'b1, 64'h1000, 64'h2000);
    push_dir(1'b1, {64{1'b1}}, {64{1'b1}});
    push_dir(1'b0, 64'h0000_7fff_ffff_f000, 64'h1000);
    push_dir(1'b0, 64'h0000_7fff_ffff_f000, 64'h1001);
    push_dir(1'b0, 64'hffff_8000_0000_0000, 64'h10);
    push_dir(1'b0, 64'h0000_8000_0000_0000, 64'h0);
    push_dir(1'b0, 64'h8000_0000_0000_0000, 64'h0);
    push_dir(1'b1, 64'h0, 64'h0100_0000_0000_0000);
    drain();

    write_reg(ucp_pkg::REG_ALIGN, 64'd16);
    write_reg(ucp_pkg::REG_MIN, 64'd8);
    write_reg(ucp_pkg::REG_MAX, 64'd4096);
    write_reg(ucp_pkg::REG_UNIT, 64'd8);
    write_reg(ucp_pkg::REG_VA, 64'd57);
    push_dir(1'b0, 64'h1008, 64'd16);
    push_dir(1'b0, 64'h1000, 64'd4);
    push_dir(1'b0, 64'h1000, 64'd8192);
    push_dir(1'b0, 64'h1000, 64'd12);
    push_dir(1'b0, 64'h00ff_ffff_ffff_fff0, 64'd16);
    push_dir(1'b0, 64'h0080_0000_0000_0000, 64'd16);
    drain();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'd1); write_reg(ucp_pkg::REG_MIN, 64'd0);
          write_reg(ucp_pkg::REG_MAX, {64{1'b1}}); write_reg(ucp_pkg::REG_UNIT, 64'd1);
          write_reg(ucp_pkg::REG_VA, 64'd48);
        end
        1: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'd65536);
          write_reg(ucp_pkg::REG_UNIT, 64'hFFFF_FFFF);
          write_reg(ucp_pkg::REG_VA, 64'd57);
        end
        2: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'd0); write_reg(ucp_pkg::REG_UNIT, 64'd0);
          write_reg(ucp_pkg::REG_VA, 64'd0);
        end
        3: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'd8); write_reg(ucp_pkg::REG_UNIT, 64'd3);
          write_reg(ucp_pkg::REG_MIN, 64'd16); write_reg(ucp_pkg::REG_MAX, 64'd2048);
          write_reg(ucp_pkg::REG_VA, 64'd63);
        end
        4: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'd6); write_reg(ucp_pkg::REG_MIN, 64'd100);
          write_reg(ucp_pkg::REG_MAX, 64'd10); write_reg(ucp_pkg::REG_VA, 64'd52);
        end
        5: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'h1FFFF);
          write_reg(ucp_pkg::REG_MIN, {64{1'b1}});
          write_reg(ucp_pkg::REG_MAX, {64{1'b1}});
          write_reg(ucp_pkg::REG_UNIT, 64'h8000_0000);
        end
        default: begin
          write_reg(ucp_pkg::REG_ALIGN, 64'd4); write_reg(ucp_pkg::REG_MIN, 64'd0);
          write_reg(ucp_pkg::REG_MAX, 64'd4096); write_reg(ucp_pkg::REG_UNIT, 64'd4);
          write_reg(ucp_pkg::REG_VA, 64'd48);
          cfg_index <= 3'd7;
          cfg_wdata <= 64'd5;
          cfg_wr_en <= 1'b1;
          @(posedge clk);
          cfg_wr_en <= 1'b0;
        end
      endcase
      quiet = (ph == 3);
      repeat (250) pending_q.push_back(rand_req());
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
